@@ src/char_lcd_write_sequencer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD write sequencer
// Both forms collapse to nothing when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked under reset release only
`define CLWS_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define CLWS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define CLWS_ASSERT(lbl, ck, rst_n, prop, msg)
`define CLWS_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

@@ src/clws_pkg.sv @@
// ---------------------------------------------------------------------------
// clws_pkg
// Shared types, codes and the power-up command table for the LCD sequencer.
// ---------------------------------------------------------------------------
package clws_pkg;

	// request codes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_CMD   = 3'd1;
	localparam logic [2:0] OP_CHAR  = 3'd2;
	localparam logic [2:0] OP_INIT  = 3'd3;
	localparam logic [2:0] OP_GOTO  = 3'd4;
	localparam logic [2:0] OP_CLEAR = 3'd5;

	// register indexes (byte address bits 3:2)
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_HIGH   = 2'd1;
	localparam logic [1:0] REG_SETTLE = 2'd2;
	localparam logic [1:0] REG_PWRUP  = 2'd3;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] LINE0_BASE = 8'h80;
	localparam logic [7:0] LINE1_BASE = 8'hC0;

	typedef struct packed {
		logic        four_bit_mode;
		logic [7:0]  enable_high_ticks;
		logic [7:0]  settle_ticks;
		logic [15:0] power_up_ticks;
	} cfg_t;

	typedef struct packed {
		logic       reg_select;
		logic       enable_pin;
		logic [7:0] data_pins;
		logic       busy_res;
		logic       rejected;
	} result_t;

	function automatic logic [2:0] init_len(input logic four);
		return four ? 3'd6 : 3'd4;
	endfunction

	function automatic logic [7:0] init_cmd(input logic four, input logic [2:0] idx);
		logic [7:0] c;
		if (four) begin
			case (idx)
				3'd0: c = 8'h33;
				3'd1: c = 8'h32;
				3'd2: c = 8'h28;
				3'd3: c = 8'h0C;
				3'd4: c = 8'h01;
				3'd5: c = 8'h02;
				default: c = 8'h33;
			endcase
		end else begin
			case (idx)
				3'd0: c = 8'h38;
				3'd1: c = 8'h0C;
				3'd2: c = 8'h01;
				3'd3: c = 8'h02;
				default: c = 8'h38;
			endcase
		end
		return c;
	endfunction

endpackage

@@ src/clws_regs.sv @@
// ---------------------------------------------------------------------------
// clws_regs
// APB register file: mode, enable-high, settle and power-up tick counts.
// ---------------------------------------------------------------------------
module clws_regs
	import clws_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_mode     <= 1'b1;
			cfg_q.enable_high_ticks <= 8'd1;
			cfg_q.settle_ticks      <= 8'd5;
			cfg_q.power_up_ticks    <= 16'd1000;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MODE:   cfg_q.four_bit_mode     <= pwdata[0];
				REG_HIGH:   cfg_q.enable_high_ticks <= pwdata[7:0];
				REG_SETTLE: cfg_q.settle_ticks      <= pwdata[7:0];
				REG_PWRUP:  cfg_q.power_up_ticks    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:   prdata = {31'd0, cfg_q.four_bit_mode};
			REG_HIGH:   prdata = {24'd0, cfg_q.enable_high_ticks};
			REG_SETTLE: prdata = {24'd0, cfg_q.settle_ticks};
			REG_PWRUP:  prdata = {16'd0, cfg_q.power_up_ticks};
			default:    prdata = '0;
		endcase
	end

endmodule

@@ src/clws_core.sv @@
// ---------------------------------------------------------------------------
// clws_core
// Pin sequencer state and its next-state logic; one item applied per advance.
// ---------------------------------------------------------------------------
`include "char_lcd_write_sequencer_assert.svh"

module clws_core
	import clws_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  cfg_t       cfg,
	input  logic [2:0] opcode,
	input  logic [7:0] data_byte,
	input  logic       row,
	input  logic [5:0] column,
	output result_t    res
);

	typedef enum logic [1:0] {PH_IDLE, PH_POWERUP, PH_EN_HIGH, PH_EN_LOW} phase_t;

	phase_t      phase_q, n_phase;
	logic [15:0] tick_q, n_tick, tick_dec;
	logic [7:0]  pend_byte_q, n_pend_byte;
	logic        pend_rs_q, n_pend_rs;
	logic        low_next_q, n_low_next;
	logic [2:0]  step_q, n_step, step_inc;
	logic        init_q, n_init;
	logic [7:0]  pin_q, n_pin;

	logic        start;
	logic [7:0]  sb_byte;
	logic        sb_rs;
	logic        rej;
	logic [15:0] high_len, settle_len;
	logic [7:0]  goto_addr;

	assign high_len   = (cfg.enable_high_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.enable_high_ticks};
	assign settle_len = (cfg.settle_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.settle_ticks};
	assign tick_dec   = (tick_q != 16'd0) ? tick_q - 16'd1 : 16'd0;
	assign step_inc   = step_q + 3'd1;
	assign goto_addr  = (row ? LINE1_BASE : LINE0_BASE) + {2'b00, column};

	always_comb begin
		n_phase     = phase_q;
		n_tick      = tick_q;
		n_pend_byte = pend_byte_q;
		n_pend_rs   = pend_rs_q;
		n_low_next  = low_next_q;
		n_step      = step_q;
		n_init      = init_q;
		n_pin       = pin_q;
		start       = 1'b0;
		sb_byte     = 8'd0;
		sb_rs       = 1'b0;
		rej         = 1'b0;

		if (opcode == OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				n_tick = tick_dec;
				if (tick_dec == 16'd0) begin
					case (phase_q)
						PH_POWERUP: begin
							if (step_q < init_len(cfg.four_bit_mode)) begin
								start   = 1'b1;
								sb_byte = init_cmd(cfg.four_bit_mode, step_q);
							end else begin
								n_init  = 1'b0;
								n_step  = 3'd0;
								n_phase = PH_IDLE;
							end
						end
						PH_EN_HIGH: begin
							n_phase = PH_EN_LOW;
							n_tick  = settle_len;
						end
						PH_EN_LOW: begin
							if (low_next_q) begin
								n_pin      = {1'b0, pend_byte_q[3:0], 3'b000};
								n_low_next = 1'b0;
								n_phase    = PH_EN_HIGH;
								n_tick     = high_len;
							end else if (init_q) begin
								// step on through the power-up list
								if (step_inc < init_len(cfg.four_bit_mode)) begin
									n_step  = step_inc;
									start   = 1'b1;
									sb_byte = init_cmd(cfg.four_bit_mode, step_inc);
								end else begin
									n_init  = 1'b0;
									n_step  = 3'd0;
									n_phase = PH_IDLE;
								end
							end else begin
								n_phase = PH_IDLE;
							end
						end
						default: ;
					endcase
				end
			end
		end else if (opcode <= OP_CLEAR) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				case (opcode)
					OP_CMD: begin
						start   = 1'b1;
						sb_byte = data_byte;
					end
					OP_CHAR: begin
						start   = 1'b1;
						sb_byte = data_byte;
						sb_rs   = 1'b1;
					end
					OP_INIT: begin
						n_init     = 1'b1;
						n_step     = 3'd0;
						n_low_next = 1'b0;
						n_phase    = PH_POWERUP;
						n_tick     = cfg.power_up_ticks;
					end
					OP_GOTO: begin
						start   = 1'b1;
						sb_byte = goto_addr;
					end
					OP_CLEAR: begin
						start   = 1'b1;
						sb_byte = CMD_CLEAR;
					end
					default: ;
				endcase
			end
		end

		if (start) begin
			n_pend_byte = sb_byte;
			n_pend_rs   = sb_rs;
			if (cfg.four_bit_mode) begin
				n_pin      = {1'b0, sb_byte[7:4], 3'b000};
				n_low_next = 1'b1;
			end else begin
				n_pin      = sb_byte;
				n_low_next = 1'b0;
			end
			n_phase = PH_EN_HIGH;
			n_tick  = high_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= 16'd0;
			pend_byte_q <= 8'd0;
			pend_rs_q   <= 1'b0;
			low_next_q  <= 1'b0;
			step_q      <= 3'd0;
			init_q      <= 1'b0;
			pin_q       <= 8'd0;
		end else if (adv) begin
			phase_q     <= n_phase;
			tick_q      <= n_tick;
			pend_byte_q <= n_pend_byte;
			pend_rs_q   <= n_pend_rs;
			low_next_q  <= n_low_next;
			step_q      <= n_step;
			init_q      <= n_init;
			pin_q       <= n_pin;
		end
	end

	assign res.reg_select = n_pend_rs;
	assign res.enable_pin = (n_phase == PH_EN_HIGH);
	assign res.data_pins  = n_pin;
	assign res.busy_res   = (n_phase != PH_IDLE);
	assign res.rejected   = rej;

	`CLWS_ASSERT_ALWAYS(a_idle_no_init, clk, (phase_q == PH_IDLE) |-> !init_q, "init flag set while idle")
	`CLWS_ASSERT_ALWAYS(a_step_range, clk, step_q <= 3'd5, "init step beyond list")
	`CLWS_ASSERT(a_reject_holds, clk, arst_n, adv && rej |=> $stable(phase_q) && $stable(tick_q), "rejected request changed state")

endmodule

@@ src/char_lcd_write_sequencer.sv @@
// ---------------------------------------------------------------------------
// char_lcd_write_sequencer
// Character LCD bus driver: RS, EN and data pin levels from ticks and requests.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one word per tick or request:
// opcode, data_byte, row, column. Output channel (out_valid/out_stall)
// returns exactly one word per input word with the pin levels after that
// item, busy and a rejected flag for requests dropped while busy.
// Timing registers and the 4/8-bit mode sit behind the APB port; write them
// only while nothing is in flight.
// A word passes through the input register, then the sequencer update and
// the result register. One word per cycle is sustained while the receiver
// does not stall; the sequencer state update sits between those registers.
// Reset clears the sequencer to idle with all pins low and loads the
// register defaults (4-bit mode, EN high 1 tick, settle 5, power-up 1000).
// While the receiver stalls, a full result register holds its word and the
// input register holds the next; in_stall rises only when both are full.
// ---------------------------------------------------------------------------
`include "char_lcd_write_sequencer_assert.svh"

module char_lcd_write_sequencer
	import clws_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        opcode,
	input  logic [7:0]        data_byte,
	input  logic              row,
	input  logic [5:0]        column,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              reg_select,
	output logic              enable_pin,
	output logic [7:0]        data_pins,
	output logic              busy_res,
	output logic              rejected
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic       out_valid_s2;
	logic       valid_s1;
	logic [2:0] opcode_s1;
	logic [7:0] data_byte_s1;
	logic       row_s1;
	logic [5:0] column_s1;
	logic       adv;
	logic       load_s1;

	clws_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// stage 1 moves on whenever the result register is free or draining
	assign adv      = valid_s1 & ~(out_valid_s2 & out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign load_s1  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			opcode_s1    <= opcode;
			data_byte_s1 <= data_byte;
			row_s1       <= row;
			column_s1    <= column;
		end
	end

	clws_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg),
		.opcode   (opcode_s1),
		.data_byte(data_byte_s1),
		.row      (row_s1),
		.column   (column_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = out_valid_s2;
	assign reg_select = res_s2.reg_select;
	assign enable_pin = res_s2.enable_pin;
	assign data_pins  = res_s2.data_pins;
	assign busy_res   = res_s2.busy_res;
	assign rejected   = res_s2.rejected;

	`CLWS_ASSERT(a_stall_only_full, clk, arst_n, in_stall |-> valid_s1 && out_valid_s2 && out_stall, "input stalled with room")
	`CLWS_ASSERT(a_adv_fills, clk, arst_n, adv |=> out_valid_s2, "advanced word lost")
	`CLWS_ASSERT(a_reject_busy, clk, arst_n, out_valid_s2 && rejected |-> busy_res, "rejected word not busy")

endmodule
